// File: sv/assert_macros.svh
// Assertion macros for the checker file rgbxy_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rgbxy_pkg.sv
`default_nettype none
package rgbxy_pkg;

  typedef struct packed {
    logic valid;
    logic on;
    logic zero;
  } ctl_t;

  localparam int QW = 16;
  localparam logic [QW-1:0] D65_X = 16'd21148;
  localparam logic [QW-1:0] D65_Y = 16'd21561;

  localparam logic [19:0] M_XR = 20'd664511;
  localparam logic [19:0] M_XG = 20'd154324;
  localparam logic [19:0] M_XB = 20'd162028;
  localparam logic [19:0] M_YR = 20'd283881;
  localparam logic [19:0] M_YG = 20'd668433;
  localparam logic [19:0] M_YB = 20'd47685;
  localparam logic [19:0] M_ZR = 20'd88;
  localparam logic [19:0] M_ZG = 20'd72310;
  localparam logic [19:0] M_ZB = 20'd986039;

  // Linearised sRGB code, truncated to f fraction bits, found by exact integer search.
  function automatic logic [24:0] lin_entry(input int c, input int f);
    logic [399:0] rhs;
    logic [399:0] lhs;
    logic [399:0] q12;
    logic [24:0]  lo;
    logic [24:0]  hi;
    logic [24:0]  mid;
    logic [63:0]  t;
    if (c <= 10) begin
      t = (64'(c) * 64'd100) << f;
      return 25'(t / 64'd329460);
    end
    rhs = 400'd1;
    for (int k = 0; k < 12; k++) rhs = rhs * 400'(1000 * c + 14025);
    rhs = rhs << (5 * f);
    q12 = 400'd1;
    for (int k = 0; k < 12; k++) q12 = q12 * 400'd269025;
    lo = 25'd0;
    hi = 25'd1 << f;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 25'd1) >> 1);
      lhs = 400'd1;
      for (int k = 0; k < 5; k++) lhs = lhs * 400'(mid);
      lhs = lhs * q12;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 25'd1;
    end
    return lo;
  endfunction

endpackage
`default_nettype wire

// File: sv/rgb_to_cie_xy_brightness_core.sv
// Throughput: one request per cycle; busy is always low.
// The input, ROM lookup and matrix registers come first, then a row of 16 divider cells
// each resolves one quotient bit of x, y and brightness, then one output register.
// Reset (synchronous, active low) clears the valid bits; the ROM is constant.
`default_nettype none
module rgb_to_cie_xy_brightness_core import rgbxy_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  output logic [15:0]      out_chroma_x,
  output logic [15:0]      out_chroma_y,
  output logic [7:0]       out_brightness,
  output logic             out_lamp_on
);
  localparam int F  = FRACTION_BITS;
  localparam int LW = F + 1;
  localparam int PW = LW + 20;
  localparam int SW = F + 22;
  localparam int NW = SW + 16;
  localparam int BW = F + 28;
  localparam int NC = QW;

  logic [LW-1:0] rom_w [256];
  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam logic [24:0] E = lin_entry(g, F);
    assign rom_w[g] = E[LW-1:0];
  end

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_on_r, s2_on_r, s3_on_r, s4_on_r;
  logic [7:0] r_r, g_r, b_r;
  logic [LW-1:0] lr_r, lg_r, lb_r;
  logic [PW-1:0] p_r [9];
  logic [SW-1:0] xn_r, yn_r, zn_r, sn_nxt;
  ctl_t s5_ctl_r;
  logic [SW-1:0] sn_r;
  logic [NW-1:0] nx_r, ny_r;
  logic [BW-1:0] nb_r;

  assign busy = 1'b0;
  assign sn_nxt = xn_r + yn_r + zn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_ctl_r <= '0;
    end else begin
      s1_v_r         <= start && !busy;
      s2_v_r         <= s1_v_r;
      s3_v_r         <= s2_v_r;
      s4_v_r         <= s3_v_r;
      s5_ctl_r.valid <= s4_v_r;
      s5_ctl_r.on    <= s4_on_r;
      s5_ctl_r.zero  <= (sn_nxt == '0);
    end
    r_r     <= in_red;
    g_r     <= in_green;
    b_r     <= in_blue;
    s1_on_r <= (in_red | in_green | in_blue) != 8'd0;
    lr_r    <= rom_w[r_r];
    lg_r    <= rom_w[g_r];
    lb_r    <= rom_w[b_r];
    s2_on_r <= s1_on_r;
    p_r[0]  <= PW'(lr_r) * PW'(M_XR);
    p_r[1]  <= PW'(lg_r) * PW'(M_XG);
    p_r[2]  <= PW'(lb_r) * PW'(M_XB);
    p_r[3]  <= PW'(lr_r) * PW'(M_YR);
    p_r[4]  <= PW'(lg_r) * PW'(M_YG);
    p_r[5]  <= PW'(lb_r) * PW'(M_YB);
    p_r[6]  <= PW'(lr_r) * PW'(M_ZR);
    p_r[7]  <= PW'(lg_r) * PW'(M_ZG);
    p_r[8]  <= PW'(lb_r) * PW'(M_ZB);
    s3_on_r <= s2_on_r;
    xn_r    <= SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]);
    yn_r    <= SW'(p_r[3]) + SW'(p_r[4]) + SW'(p_r[5]);
    zn_r    <= SW'(p_r[6]) + SW'(p_r[7]) + SW'(p_r[8]);
    s4_on_r <= s3_on_r;
    sn_r    <= sn_nxt;
    nx_r    <= NW'(xn_r) << 16;
    ny_r    <= NW'(yn_r) << 16;
    nb_r    <= BW'(yn_r) * BW'(254);
  end

  ctl_t          ctl_w [NC+1];
  logic [SW-1:0] d_w   [NC+1];
  logic [NW-1:0] nx_w  [NC+1];
  logic [NW-1:0] ny_w  [NC+1];
  logic [BW-1:0] nb_w  [NC+1];
  logic [QW-1:0] qx_w  [NC+1];
  logic [QW-1:0] qy_w  [NC+1];
  logic [QW-1:0] qb_w  [NC+1];

  assign ctl_w[0] = s5_ctl_r;
  assign d_w[0]   = sn_r;
  assign nx_w[0]  = nx_r;
  assign ny_w[0]  = ny_r;
  assign nb_w[0]  = nb_r;
  assign qx_w[0]  = '0;
  assign qy_w[0]  = '0;
  assign qb_w[0]  = '0;

  for (genvar j = 0; j < NC; j++) begin : g_cell
    rgbxy_div_cell #(.FB(F), .SH(NC - 1 - j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_w[j]),
      .d_i   (d_w[j]),
      .nx_i  (nx_w[j]),
      .ny_i  (ny_w[j]),
      .nb_i  (nb_w[j]),
      .qx_i  (qx_w[j]),
      .qy_i  (qy_w[j]),
      .qb_i  (qb_w[j]),
      .ctl_o (ctl_w[j+1]),
      .d_o   (d_w[j+1]),
      .nx_o  (nx_w[j+1]),
      .ny_o  (ny_w[j+1]),
      .nb_o  (nb_w[j+1]),
      .qx_o  (qx_w[j+1]),
      .qy_o  (qy_w[j+1]),
      .qb_o  (qb_w[j+1])
    );
  end

  ctl_t          fin;
  logic          out_valid_r;
  logic [15:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [7:0]    bri_r, bri_nxt;
  logic          on_r;

  assign fin = ctl_w[NC];

  always_comb begin
    cx_nxt  = qx_w[NC];
    cy_nxt  = qy_w[NC];
    bri_nxt = qb_w[NC][7:0];
    if (fin.zero) begin
      cx_nxt = D65_X;
      cy_nxt = D65_Y;
    end
    if (!fin.on) begin
      bri_nxt = 8'd0;
    end else if (bri_nxt == 8'd0) begin
      bri_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    bri_r <= bri_nxt;
    on_r  <= fin.on;
  end

  assign out_valid      = out_valid_r;
  assign out_chroma_x   = cx_r;
  assign out_chroma_y   = cy_r;
  assign out_brightness = bri_r;
  assign out_lamp_on    = on_r;
endmodule
`default_nettype wire

// File: sv/rgbxy_div_cell.sv
`default_nettype none
module rgbxy_div_cell import rgbxy_pkg::*; #(
  parameter int FB = 16,
  parameter int SH = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_t               ctl_i,
  input  wire logic [FB+21:0]     d_i,
  input  wire logic [FB+37:0]     nx_i,
  input  wire logic [FB+37:0]     ny_i,
  input  wire logic [FB+27:0]     nb_i,
  input  wire logic [QW-1:0]      qx_i,
  input  wire logic [QW-1:0]      qy_i,
  input  wire logic [QW-1:0]      qb_i,
  output ctl_t                    ctl_o,
  output logic [FB+21:0]          d_o,
  output logic [FB+37:0]          nx_o,
  output logic [FB+37:0]          ny_o,
  output logic [FB+27:0]          nb_o,
  output logic [QW-1:0]           qx_o,
  output logic [QW-1:0]           qy_o,
  output logic [QW-1:0]           qb_o
);
  localparam int NW = FB + 38;
  localparam int BW = FB + 28;
  localparam int EW = BW + QW;
  localparam logic [EW-1:0] BDS = (EW'(1000000) << FB) << SH;

  ctl_t ctl_r;
  logic [FB+21:0] d_r;
  logic [NW-1:0] nx_r, nx_nxt, ny_r, ny_nxt, dsh;
  logic [BW-1:0] nb_r, nb_nxt;
  logic [QW-1:0] qx_r, qx_nxt, qy_r, qy_nxt, qb_r, qb_nxt;
  logic [EW-1:0] nb_ext;

  always_comb begin
    dsh    = NW'(d_i) << SH;
    nb_ext = EW'(nb_i);
    nx_nxt = nx_i;
    ny_nxt = ny_i;
    nb_nxt = nb_i;
    qx_nxt = qx_i;
    qy_nxt = qy_i;
    qb_nxt = qb_i;
    if (nx_i >= dsh) begin
      nx_nxt     = nx_i - dsh;
      qx_nxt[SH] = 1'b1;
    end
    if (ny_i >= dsh) begin
      ny_nxt     = ny_i - dsh;
      qy_nxt[SH] = 1'b1;
    end
    if (nb_ext >= BDS) begin
      nb_nxt     = BW'(nb_ext - BDS);
      qb_nxt[SH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    d_r  <= d_i;
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    nb_r <= nb_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    qb_r <= qb_nxt;
  end

  assign ctl_o = ctl_r;
  assign d_o   = d_r;
  assign nx_o  = nx_r;
  assign ny_o  = ny_r;
  assign nb_o  = nb_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;
  assign qb_o  = qb_r;
endmodule
`default_nettype wire

// File: sv/rgbxy_chk.sv
`default_nettype none
`include "assert_macros.svh"
module rgbxy_chk import rgbxy_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [7:0]  in_red,
  input wire logic [7:0]  in_green,
  input wire logic [7:0]  in_blue,
  input wire logic        out_valid,
  input wire logic [15:0] out_chroma_x,
  input wire logic [15:0] out_chroma_y,
  input wire logic [7:0]  out_brightness,
  input wire logic        out_lamp_on
);
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe straight after reset")
  `ASSERT_CLK(a_never_busy, !busy, "busy raised")
  `ASSERT_CLK(a_dark_point, out_valid && !out_lamp_on |-> out_brightness == 8'd0 && out_chroma_x == D65_X && out_chroma_y == D65_Y, "black colour not at white point")
  `ASSERT_CLK(a_lit_bright, out_valid && out_lamp_on |-> out_brightness != 8'd0 && out_brightness <= 8'd254, "lit colour brightness out of range")
endmodule

bind rgb_to_cie_xy_brightness_core rgbxy_chk u_rgbxy_chk (.*);
`default_nettype wire
